>>> rtl/msfir_pkg.sv
// ----------------------------------------------------------------------------
// msfir_pkg
// Shared types and constants for the mono to stereo FIR convolver.
// ----------------------------------------------------------------------------
package msfir_pkg;

    // Beat kinds on the input channel
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Config register reset value (taps in use)
    localparam logic [8:0] TAPS_RESET = 9'd128;

    // Input beat payload
    typedef struct packed {
        logic               kind;
        logic [7:0]         tap_index;
        logic signed [15:0] coef_left;
        logic signed [15:0] coef_right;
        logic signed [15:0] sample;
    } in_beat_t;

    // Output beat payload
    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } out_beat_t;

    // One coefficient pair as held in the tap memory
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } coef_pair_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_FIN
    } state_t;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;
        logic issue;
        logic last;
        logic hist_ok;
    } mac_ctl_t;

endpackage

>>> rtl/mono_to_stereo_fir_convolver_core.sv
// ----------------------------------------------------------------------------
// mono_to_stereo_fir_convolver_core
// Mono in, stereo out FIR with two kernels sharing one delay line.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------
//   in       | in        | in_valid / in_ready | msfir_pkg::in_beat_t
//   out      | out       | out_valid/out_ready | msfir_pkg::out_beat_t
//   cfg      | in        | cfg_we (no wait)    | cfg_wdata, taps in use
//
// A tap load beat is written into the tap memory. A sample beat holds the
// input for one MAC per tap in use (clamped to MAX_TAPS, none when zero)
// for both channels, then pipeline drain and hand-off to the output register.
// The next sample may start while that result waits; a finished sum waits
// for the register to free up, and the input stalls meanwhile.
// Reset clears control and the history fill count; no clearing pass.
// ----------------------------------------------------------------------------
module mono_to_stereo_fir_convolver_core #(
    parameter int MAX_TAPS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  msfir_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output msfir_pkg::out_beat_t out_data,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_wdata
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 32 + CW;

    logic [8:0]            taps_reg;
    logic                  out_valid_reg, out_valid_next;
    msfir_pkg::out_beat_t  out_data_reg;

    logic                  out_free, out_load;
    logic                  tap_we;
    logic                  hist_we;
    logic [AW-1:0]         hist_waddr, hist_raddr, tap_raddr;
    msfir_pkg::mac_ctl_t   mac_ctl;
    logic                  mac_done;
    msfir_pkg::out_beat_t  mac_res;

    msfir_pkg::coef_pair_t tap_mem [MAX_TAPS];
    logic signed [15:0]    hist_mem [MAX_TAPS];
    msfir_pkg::coef_pair_t tap_q;
    logic signed [15:0]    hist_q;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= msfir_pkg::TAPS_RESET;
        end
        else if (cfg_we)
        begin
            taps_reg <= cfg_wdata;
        end
    end

    // Tap memory: written by tap load beats, read once per MAC
    assign tap_we = in_valid && in_ready && (in_data.kind == msfir_pkg::KIND_TAP)
                    && (int'(in_data.tap_index) < MAX_TAPS);

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[AW'(in_data.tap_index)] <= {in_data.coef_left, in_data.coef_right};
        end
        tap_q <= tap_mem[tap_raddr];
    end

    // History memory: circular delay line
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= in_data.sample;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    msfir_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_kind     (in_data.kind),
        .taps_in_use (taps_reg),
        .mac_done    (mac_done),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .out_load    (out_load),
        .hist_we     (hist_we),
        .hist_waddr  (hist_waddr),
        .hist_raddr  (hist_raddr),
        .tap_raddr   (tap_raddr),
        .mac_ctl     (mac_ctl)
    );

    msfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .hist_q (hist_q),
        .coef_q (tap_q),
        .done   (mac_done),
        .res    (mac_res)
    );

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/msfir_mac.sv
// ----------------------------------------------------------------------------
// msfir_mac
// Shared dual multiply-accumulate unit: one tap per cycle for both channels,
// then floor shift by 15 and int16 saturation.
// ----------------------------------------------------------------------------
module msfir_mac #(
    parameter int ACC_W = 41
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msfir_pkg::mac_ctl_t   ctl,
    input  logic signed [15:0]    hist_q,
    input  msfir_pkg::coef_pair_t coef_q,
    output logic                  done,
    output msfir_pkg::out_beat_t  res
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(32768));

    // stage 1: aligned with the registered memory read data
    logic v1_reg, last1_reg, ok1_reg;
    // stage 2: registered products
    logic v2_reg, last2_reg;
    logic signed [31:0] prod_l_reg, prod_r_reg;
    // accumulators
    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;
    logic done_reg;

    // Floor shift right by 15, then clamp to int16
    function automatic logic signed [15:0] scale_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> 15;
        if (sh > SAT_MAX) begin
            scale_sat = 16'sd32767;
        end else if (sh < SAT_MIN) begin
            scale_sat = -16'sd32768;
        end else begin
            scale_sat = sh[15:0];
        end
    endfunction

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            ok1_reg   <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= ctl.issue;
            last1_reg <= ctl.issue && ctl.last;
            ok1_reg   <= ctl.hist_ok;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            done_reg  <= v2_reg && last2_reg;
        end
    end

    // Multiply; history entries never written count as zero
    always_ff @(posedge clk)
    begin
        if (ok1_reg)
        begin
            prod_l_reg <= hist_q * coef_q.left;
            prod_r_reg <= hist_q * coef_q.right;
        end
        else
        begin
            prod_l_reg <= '0;
            prod_r_reg <= '0;
        end
    end

    // Accumulate
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
    end

    assign done             = done_reg;
    assign res.left_sample  = scale_sat(acc_l_reg);
    assign res.right_sample = scale_sat(acc_r_reg);

endmodule

>>> rtl/msfir_ctrl.sv
// ----------------------------------------------------------------------------
// msfir_ctrl
// Sequencer: delay line pointer and fill count, tap walk, result hand-off.
// ----------------------------------------------------------------------------
module msfir_ctrl #(
    parameter int MAX_TAPS = 256,
    parameter int AW       = 8,
    parameter int CW       = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    input  logic [8:0]          taps_in_use,
    input  logic                mac_done,
    input  logic                out_free,
    output logic                in_ready,
    output logic                out_load,
    output logic                hist_we,
    output logic [AW-1:0]       hist_waddr,
    output logic [AW-1:0]       hist_raddr,
    output logic [AW-1:0]       tap_raddr,
    output msfir_pkg::mac_ctl_t mac_ctl
);

    msfir_pkg::state_t state_reg, state_next;

    logic [AW-1:0] newest_reg, newest_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] n_reg, n_next;

    logic          accept_sample;
    logic [AW-1:0] newest_dec;
    logic [CW-1:0] n_clamp;
    logic          k_last;

    assign accept_sample = in_valid && in_ready && (in_kind == msfir_pkg::KIND_SAMPLE);
    assign newest_dec    = (newest_reg == '0) ? AW'(MAX_TAPS - 1) : newest_reg - AW'(1);
    assign n_clamp       = (int'(taps_in_use) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(taps_in_use);
    assign k_last        = (CW'(k_reg) == n_reg - CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msfir_pkg::ST_IDLE:
                if (accept_sample)
                begin
                    state_next = (n_clamp == '0) ? msfir_pkg::ST_FIN : msfir_pkg::ST_RUN;
                end
            msfir_pkg::ST_RUN:
                if (k_last)
                begin
                    state_next = msfir_pkg::ST_WAIT;
                end
            msfir_pkg::ST_WAIT:
                if (mac_done)
                begin
                    state_next = msfir_pkg::ST_FIN;
                end
            msfir_pkg::ST_FIN:
                if (out_free)
                begin
                    state_next = msfir_pkg::ST_IDLE;
                end
            default:
                state_next = msfir_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready        = (state_reg == msfir_pkg::ST_IDLE);
        out_load        = (state_reg == msfir_pkg::ST_FIN) && out_free;
        mac_ctl.clear   = accept_sample;
        mac_ctl.issue   = (state_reg == msfir_pkg::ST_RUN);
        mac_ctl.last    = k_last;
        mac_ctl.hist_ok = (CW'(k_reg) < fill_reg);
        hist_we         = accept_sample;
        hist_waddr      = newest_dec;
        hist_raddr      = pos_reg;
        tap_raddr       = k_reg;
    end

    // Counters and pointers
    always_comb
    begin
        newest_next = newest_reg;
        fill_next   = fill_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        if (accept_sample)
        begin
            newest_next = newest_dec;
            n_next      = n_clamp;
            k_next      = '0;
            pos_next    = newest_dec;
            if (fill_reg != CW'(MAX_TAPS))
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
        else if (state_reg == msfir_pkg::ST_RUN)
        begin
            k_next   = k_reg + AW'(1);
            pos_next = (pos_reg == AW'(MAX_TAPS - 1)) ? '0 : pos_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= msfir_pkg::ST_IDLE;
            newest_reg <= '0;
            fill_reg   <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            fill_reg   <= fill_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono to stereo FIR convolver core.
// Tap pair and sample beats go in over valid/ready, and each sample beat is
// predicted by a local convolution over a shadow delay line and kernel pair.
// Every output beat is compared field by field in arrival order. The run
// steps through several filter lengths, including zero and values past the
// kernel depth, with random idle gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_DEPTH    = 256;
    localparam int TAP_AW       = $clog2(TAP_DEPTH);
    localparam int SETTLE_CYC   = TAP_DEPTH + 16;
    localparam int STALL_LIMIT  = 10000;
    localparam int HOLDOFF_CYC  = 600;

    // DUT ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    msfir_pkg::in_beat_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    msfir_pkg::out_beat_t out_data;
    logic                 cfg_we    = 1'b0;
    logic [8:0]           cfg_wdata = '0;

    // Shadow state of the filter
    logic signed [15:0] kern_left  [TAP_DEPTH];
    logic signed [15:0] kern_right [TAP_DEPTH];
    bit                 tap_loaded [TAP_DEPTH];
    logic signed [15:0] delay_line [TAP_DEPTH];
    logic [8:0]         taps_cfg = msfir_pkg::TAPS_RESET;

    msfir_pkg::out_beat_t pending_stereo [$];

    // Run bookkeeping
    int  err_count     = 0;
    int  tap_loads     = 0;
    int  samples_sent  = 0;
    int  results_seen  = 0;
    int  sat_outputs   = 0;
    int  cfg_writes    = 0;
    int  idle_cycles   = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;
    int  rx_holdoff    = 0;
    int  rx_stall_left = 0;

    mono_to_stereo_fir_convolver_core #(
        .MAX_TAPS (TAP_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 50 MHz clock
    always #10 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 24);
        return $urandom_range(40, 150);
    endfunction

    // Coefficient or sample value: full scale now and then, else random width
    function automatic logic signed [15:0] rand_pcm();
        logic signed [15:0] v;
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'sh8000;
        else if (r == 1)
            return 16'sh7fff;
        v = 16'($urandom());
        return v >>> $urandom_range(0, 10);
    endfunction

    function automatic msfir_pkg::in_beat_t tap_beat(input logic [7:0] idx,
                                                     input logic signed [15:0] cl,
                                                     input logic signed [15:0] cr);
        msfir_pkg::in_beat_t b;
        b.kind       = msfir_pkg::KIND_TAP;
        b.tap_index  = idx;
        b.coef_left  = cl;
        b.coef_right = cr;
        b.sample     = 16'($urandom());
        return b;
    endfunction

    function automatic msfir_pkg::in_beat_t sample_beat(input logic signed [15:0] s);
        msfir_pkg::in_beat_t b;
        b.kind       = msfir_pkg::KIND_SAMPLE;
        b.tap_index  = 8'($urandom());
        b.coef_left  = 16'($urandom());
        b.coef_right = 16'($urandom());
        b.sample     = s;
        return b;
    endfunction

    // Floor shift by 15, then clip to int16
    function automatic logic signed [15:0] scale_to_pcm(input longint acc);
        longint s;
        s = acc >>> 15;
        if (s > 32767)
        begin
            sat_outputs++;
            return 16'sh7fff;
        end
        if (s < -32768)
        begin
            sat_outputs++;
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    // Apply one accepted beat to the shadow state; samples queue a result
    task automatic convolve_beat(input msfir_pkg::in_beat_t b);
        longint               acc_l;
        longint               acc_r;
        int                   n;
        int                   k;
        msfir_pkg::out_beat_t r;
        if (b.kind == msfir_pkg::KIND_TAP)
        begin
            kern_left[b.tap_index]  = b.coef_left;
            kern_right[b.tap_index] = b.coef_right;
            tap_loaded[b.tap_index] = 1'b1;
            tap_loads++;
        end
        else
        begin
            for (k = TAP_DEPTH - 1; k > 0; k--)
                delay_line[TAP_AW'(k)] = delay_line[TAP_AW'(k - 1)];
            delay_line[0] = b.sample;
            n = (taps_cfg > TAP_DEPTH) ? TAP_DEPTH : int'(taps_cfg);
            acc_l = 0;
            acc_r = 0;
            for (k = 0; k < n; k++)
            begin
                acc_l += longint'(delay_line[TAP_AW'(k)]) * longint'(kern_left[TAP_AW'(k)]);
                acc_r += longint'(delay_line[TAP_AW'(k)]) * longint'(kern_right[TAP_AW'(k)]);
            end
            r.left_sample  = scale_to_pcm(acc_l);
            r.right_sample = scale_to_pcm(acc_r);
            pending_stereo.push_back(r);
            samples_sent++;
        end
    endtask

    // Offer one beat, hold it until taken, then predict
    task automatic send_beat(input msfir_pkg::in_beat_t b);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        convolve_beat(b);
    endtask

    // Stop offering, let all results drain and the core go quiet
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_stereo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_taps_in_use(input logic [8:0] v);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        taps_cfg   = v;
        cfg_writes++;
    endtask

    // Load every kernel position below the given length that is still blank
    task automatic ensure_taps_loaded(input int upto);
        int i;
        for (i = 0; i < upto; i++)
            if (!tap_loaded[TAP_AW'(i)])
                send_beat(tap_beat(i[7:0], rand_pcm(), rand_pcm()));
    endtask

    // Reset length of 128 taps, before any register write
    task automatic test_reset_length();
        int i;
        ensure_taps_loaded(int'(msfir_pkg::TAPS_RESET));
        for (i = 0; i < 24; i++)
            send_beat(sample_beat(rand_pcm()));
    endtask

    // Full scale, rounding, clipping and the zero length
    task automatic test_directed_corners();
        write_taps_in_use(9'd1);
        send_beat(tap_beat(8'd0, 16'sh8000, 16'sh7fff));
        send_beat(sample_beat(16'sh8000));
        send_beat(sample_beat(16'sh7fff));
        send_beat(sample_beat(16'sh0000));
        // tiny products round toward minus infinity
        send_beat(tap_beat(8'd0, 16'sh0001, -16'sh0001));
        send_beat(sample_beat(-16'sh0001));
        send_beat(sample_beat(16'sh0001));
        // two full-scale taps clip both ways
        write_taps_in_use(9'd2);
        send_beat(tap_beat(8'd0, 16'sh8000, 16'sh7fff));
        send_beat(tap_beat(8'd1, 16'sh8000, 16'sh7fff));
        send_beat(sample_beat(16'sh7fff));
        send_beat(sample_beat(16'sh7fff));
        send_beat(sample_beat(16'sh8000));
        send_beat(sample_beat(16'sh8000));
        // empty sums, plus a load at the top kernel position
        write_taps_in_use(9'd0);
        send_beat(tap_beat(8'd255, 16'sh7fff, 16'sh8000));
        send_beat(sample_beat(16'sh7fff));
        send_beat(sample_beat(16'sh8000));
    endtask

    // Whole kernel, and lengths past the depth that clamp to it
    task automatic test_full_kernel();
        int i;
        ensure_taps_loaded(TAP_DEPTH);
        write_taps_in_use(9'd256);
        for (i = 0; i < 8; i++)
            send_beat(sample_beat(rand_pcm()));
        write_taps_in_use(9'd511);
        for (i = 0; i < 6; i++)
            send_beat(sample_beat(rand_pcm()));
        write_taps_in_use(9'd257);
        for (i = 0; i < 4; i++)
            send_beat(sample_beat(rand_pcm()));
    endtask

    // Long output stall fills the core and back-pressures the input
    task automatic test_output_holdoff();
        int i;
        write_taps_in_use(9'd4);
        tx_steady  = 1'b1;
        rx_holdoff = HOLDOFF_CYC;
        for (i = 0; i < 20; i++)
            send_beat(sample_beat(rand_pcm()));
        tx_steady = 1'b0;
        quiesce();
    endtask

    // Random phases: random length, mostly samples with some kernel updates
    task automatic test_random_mix();
        int         ph;
        int         i;
        int         r;
        logic [8:0] len;
        for (ph = 0; ph < 8; ph++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                len = 9'($urandom_range(1, 16));
            else if (r < 70)
                len = 9'($urandom_range(17, 64));
            else if (r < 80)
                len = 9'd0;
            else if (r < 88)
                len = 9'($urandom_range(65, 255));
            else if (r < 94)
                len = 9'd256;
            else
                len = 9'($urandom_range(257, 511));
            write_taps_in_use(len);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < 40; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(tap_beat(8'($urandom()), rand_pcm(), rand_pcm()));
                else
                    send_beat(sample_beat(rand_pcm()));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Output ready: random stalls, steady stretches, and requested hold-offs
    always @(negedge clk)
    begin : rx_drive
        int len;
        if (rx_holdoff > 0)
        begin
            rx_stall_left = rx_holdoff;
            rx_holdoff    = 0;
        end
        if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            len = gap_len();
            if (len == 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready    <= 1'b0;
                rx_stall_left = len - 1;
            end
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        msfir_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stereo.size() == 0)
            begin
                $error("unexpected output beat: left %0d right %0d",
                       out_data.left_sample, out_data.right_sample);
                err_count++;
            end
            else
            begin
                want = pending_stereo.pop_front();
                if (out_data.left_sample !== want.left_sample)
                begin
                    $error("left_sample: expected %0d, got %0d",
                           want.left_sample, out_data.left_sample);
                    err_count++;
                end
                if (out_data.right_sample !== want.right_sample)
                begin
                    $error("right_sample: expected %0d, got %0d",
                           want.right_sample, out_data.right_sample);
                    err_count++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog: too long without any beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: %0d results still outstanding",
                     pending_stereo.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence
    initial
    begin : run
        int i;
        for (i = 0; i < TAP_DEPTH; i++)
        begin
            kern_left[TAP_AW'(i)]  = '0;
            kern_right[TAP_AW'(i)] = '0;
            tap_loaded[TAP_AW'(i)] = 1'b0;
            delay_line[TAP_AW'(i)] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_directed_corners();
        test_full_kernel();
        test_output_holdoff();
        test_random_mix();

        quiesce();
        $display("Covered %0d tap loads and %0d samples (%0d results, %0d clipped outputs)",
                 tap_loads, samples_sent, results_seen, sat_outputs);
        $display("over %0d length settings incl. zero, full depth and clamped values",
                 cfg_writes + 1);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/msfir_pkg.sv
rtl/msfir_mac.sv
rtl/msfir_ctrl.sv
rtl/mono_to_stereo_fir_convolver_core.sv
tb/tb_top.sv
